@@ rtl/slt_pkg.sv @@
package slt_pkg;

    // Width of a literal value; a literal saturates at all ones.
    localparam int VALUE_BITS = 31;
    localparam int SUM_BITS   = VALUE_BITS + 4;
    localparam int QUEUE_DEPTH = 3;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [SUM_BITS-1:0]   t_sum;
    typedef logic [1:0]            t_count;

    localparam t_value VAL_MAX = {VALUE_BITS{1'b1}};

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_UPPER_S = 8'h53;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_NUMBER, M_AMP, M_BAR, M_EQ, M_BANG,
        M_LT, M_GT, M_COLON, M_SEMI
    } t_mode;

    typedef enum logic [4:0] {
        K_PUSH, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_STORE, K_LOAD,
        K_STARTIF, K_ENDIF, K_STARTWHILE, K_ENDWHILE, K_STARTFOR, K_ENDFOR,
        K_STARTFUNC, K_ENDFUNC, K_EQUAL, K_NE, K_LESS, K_GREATER, K_LE, K_GE,
        K_AND, K_OR, K_NOT, K_START, K_EXIT, K_EOF, K_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        ERR_END_OP, ERR_AMP, ERR_BAR, ERR_EQ, ERR_VAR, ERR_UNKNOWN
    } t_err;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_marker;
    } t_char;

    typedef struct packed {
        logic [4:0] token_kind;
        t_value     token_value;
        logic [2:0] error_code;
        logic       run_last;
    } t_token;

    typedef struct packed {
        t_mode  mode;
        t_value acc;
        logic   halt;
    } t_scan_state;

    typedef struct packed {
        t_count count;
        t_token tok0;
        t_token tok1;
    } t_scan_res;

endpackage

@@ rtl/slt_accum.sv @@
module slt_accum (
    input  slt_pkg::t_value i_acc,
    input  logic [3:0]      i_digit,
    output slt_pkg::t_value o_acc
);

    slt_pkg::t_sum w_wide;

    // acc * 10 + digit as two shifted adds, then clamp.
    always_comb begin
        w_wide = (slt_pkg::t_sum'(i_acc) << 3) + (slt_pkg::t_sum'(i_acc) << 1)
               + slt_pkg::t_sum'(i_digit);
        if (w_wide > slt_pkg::t_sum'(slt_pkg::VAL_MAX)) begin
            o_acc = slt_pkg::VAL_MAX;
        end else begin
            o_acc = w_wide[slt_pkg::VALUE_BITS-1:0];
        end
    end

endmodule

@@ rtl/slt_scan.sv @@
module slt_scan (
    input  slt_pkg::t_char       i_beat,
    input  slt_pkg::t_scan_state i_state,
    output slt_pkg::t_scan_state o_state,
    output slt_pkg::t_scan_res   o_res
);

    typedef struct packed {
        logic            emit;
        slt_pkg::t_kind  kind;
        slt_pkg::t_err   err;
        slt_pkg::t_mode  mode;
        logic            digit;
    } t_fresh;

    // Handling of a byte seen with no pending context.
    function automatic t_fresh f_fresh(input logic [7:0] c);
        t_fresh f;
        f = '{emit: 1'b0, kind: slt_pkg::K_PUSH, err: slt_pkg::ERR_END_OP,
              mode: slt_pkg::M_IDLE, digit: 1'b0};
        if ((c >= slt_pkg::CH_TAB && c <= slt_pkg::CH_CR) || c == slt_pkg::CH_SPACE) begin
            f.emit = 1'b0;
        end else if (c == slt_pkg::CH_HASH) begin
            f.mode = slt_pkg::M_COMMENT;
        end else if (c >= slt_pkg::CH_ZERO && c <= slt_pkg::CH_NINE) begin
            f.mode  = slt_pkg::M_NUMBER;
            f.digit = 1'b1;
        end else begin
            f.emit = 1'b1;
            case (c)
                slt_pkg::CH_PLUS:    f.kind = slt_pkg::K_ADD;
                slt_pkg::CH_MINUS:   f.kind = slt_pkg::K_SUB;
                slt_pkg::CH_STAR:    f.kind = slt_pkg::K_MUL;
                slt_pkg::CH_SLASH:   f.kind = slt_pkg::K_DIV;
                slt_pkg::CH_PCT:     f.kind = slt_pkg::K_MOD;
                slt_pkg::CH_LBRACK:  f.kind = slt_pkg::K_STARTIF;
                slt_pkg::CH_RBRACK:  f.kind = slt_pkg::K_ENDIF;
                slt_pkg::CH_LBRACE:  f.kind = slt_pkg::K_STARTWHILE;
                slt_pkg::CH_RBRACE:  f.kind = slt_pkg::K_ENDWHILE;
                slt_pkg::CH_LPAREN:  f.kind = slt_pkg::K_STARTFOR;
                slt_pkg::CH_RPAREN:  f.kind = slt_pkg::K_ENDFOR;
                slt_pkg::CH_AT:      f.kind = slt_pkg::K_STARTFUNC;
                slt_pkg::CH_DOLLAR:  f.kind = slt_pkg::K_ENDFUNC;
                slt_pkg::CH_UPPER_S: f.kind = slt_pkg::K_START;
                slt_pkg::CH_UPPER_E: f.kind = slt_pkg::K_EXIT;
                slt_pkg::CH_AMP:   begin f.emit = 1'b0; f.mode = slt_pkg::M_AMP;   end
                slt_pkg::CH_BAR:   begin f.emit = 1'b0; f.mode = slt_pkg::M_BAR;   end
                slt_pkg::CH_EQ:    begin f.emit = 1'b0; f.mode = slt_pkg::M_EQ;    end
                slt_pkg::CH_BANG:  begin f.emit = 1'b0; f.mode = slt_pkg::M_BANG;  end
                slt_pkg::CH_LT:    begin f.emit = 1'b0; f.mode = slt_pkg::M_LT;    end
                slt_pkg::CH_GT:    begin f.emit = 1'b0; f.mode = slt_pkg::M_GT;    end
                slt_pkg::CH_COLON: begin f.emit = 1'b0; f.mode = slt_pkg::M_COLON; end
                slt_pkg::CH_SEMI:  begin f.emit = 1'b0; f.mode = slt_pkg::M_SEMI;  end
                default: begin
                    f.kind = slt_pkg::K_ERROR;
                    f.err  = slt_pkg::ERR_UNKNOWN;
                end
            endcase
        end
        return f;
    endfunction

    function automatic slt_pkg::t_token f_tok(input slt_pkg::t_kind k,
                                              input slt_pkg::t_value v,
                                              input slt_pkg::t_err e);
        slt_pkg::t_token t;
        t.token_kind  = k;
        t.token_value = v;
        t.error_code  = e;
        t.run_last    = 1'b0;
        return t;
    endfunction

    logic [7:0]       w_c;
    logic             w_is_digit;
    logic             w_is_alpha;
    slt_pkg::t_value  w_acc_next;
    t_fresh           w_fresh;
    slt_pkg::t_token  w_slot [2];
    slt_pkg::t_count  w_n;
    logic             w_do_fresh;

    assign w_c        = i_beat.char_code;
    assign w_is_digit = (w_c >= slt_pkg::CH_ZERO) && (w_c <= slt_pkg::CH_NINE);
    assign w_is_alpha = ((w_c >= slt_pkg::CH_UPPER_A) && (w_c <= slt_pkg::CH_UPPER_Z))
                     || ((w_c >= slt_pkg::CH_LOWER_A) && (w_c <= slt_pkg::CH_LOWER_Z));
    assign w_fresh    = f_fresh(w_c);

    slt_accum u_accum (
        .i_acc   (i_state.acc),
        .i_digit (w_c[3:0]),
        .o_acc   (w_acc_next)
    );

    always_comb begin
        o_state    = i_state;
        w_n        = '0;
        w_do_fresh = 1'b0;
        w_slot[0]  = f_tok(slt_pkg::K_PUSH, '0, slt_pkg::ERR_END_OP);
        w_slot[1]  = f_tok(slt_pkg::K_PUSH, '0, slt_pkg::ERR_END_OP);

        if (!i_state.halt) begin
            if (i_beat.end_marker) begin
                unique case (i_state.mode) inside
                    slt_pkg::M_NUMBER: begin
                        w_slot[0] = f_tok(slt_pkg::K_PUSH, i_state.acc, slt_pkg::ERR_END_OP);
                        w_n = 2'd1;
                    end
                    slt_pkg::M_LT: begin
                        w_slot[0] = f_tok(slt_pkg::K_LESS, '0, slt_pkg::ERR_END_OP);
                        w_n = 2'd1;
                    end
                    slt_pkg::M_GT: begin
                        w_slot[0] = f_tok(slt_pkg::K_GREATER, '0, slt_pkg::ERR_END_OP);
                        w_n = 2'd1;
                    end
                    slt_pkg::M_AMP, slt_pkg::M_BAR, slt_pkg::M_EQ, slt_pkg::M_BANG: begin
                        w_slot[0] = f_tok(slt_pkg::K_ERROR, '0, slt_pkg::ERR_END_OP);
                        w_n = 2'd1;
                        o_state.halt = 1'b1;
                    end
                    slt_pkg::M_COLON, slt_pkg::M_SEMI: begin
                        w_slot[0] = f_tok(slt_pkg::K_ERROR, '0, slt_pkg::ERR_VAR);
                        w_n = 2'd1;
                        o_state.halt = 1'b1;
                    end
                    default: begin
                        w_n = 2'd0;
                    end
                endcase
                if (!o_state.halt) begin
                    w_slot[w_n[0]] = f_tok(slt_pkg::K_EOF, '0, slt_pkg::ERR_END_OP);
                    w_n = w_n + 2'd1;
                end
                o_state.mode = slt_pkg::M_IDLE;
                o_state.acc  = '0;
            end else begin
                unique case (i_state.mode) inside
                    slt_pkg::M_COMMENT: begin
                        if (w_c == slt_pkg::CH_LF) begin
                            o_state.mode = slt_pkg::M_IDLE;
                        end
                    end
                    slt_pkg::M_NUMBER: begin
                        if (w_is_digit) begin
                            o_state.acc = w_acc_next;
                        end else begin
                            w_slot[0] = f_tok(slt_pkg::K_PUSH, i_state.acc,
                                              slt_pkg::ERR_END_OP);
                            w_n = 2'd1;
                            o_state.acc = '0;
                            w_do_fresh = 1'b1;
                        end
                    end
                    slt_pkg::M_AMP: begin
                        o_state.mode = slt_pkg::M_IDLE;
                        w_n = 2'd1;
                        if (w_c == slt_pkg::CH_AMP) begin
                            w_slot[0] = f_tok(slt_pkg::K_AND, '0, slt_pkg::ERR_END_OP);
                        end else begin
                            w_slot[0] = f_tok(slt_pkg::K_ERROR, '0, slt_pkg::ERR_AMP);
                            o_state.halt = 1'b1;
                        end
                    end
                    slt_pkg::M_BAR: begin
                        o_state.mode = slt_pkg::M_IDLE;
                        w_n = 2'd1;
                        if (w_c == slt_pkg::CH_BAR) begin
                            w_slot[0] = f_tok(slt_pkg::K_OR, '0, slt_pkg::ERR_END_OP);
                        end else begin
                            w_slot[0] = f_tok(slt_pkg::K_ERROR, '0, slt_pkg::ERR_BAR);
                            o_state.halt = 1'b1;
                        end
                    end
                    slt_pkg::M_EQ: begin
                        o_state.mode = slt_pkg::M_IDLE;
                        w_n = 2'd1;
                        if (w_c == slt_pkg::CH_EQ) begin
                            w_slot[0] = f_tok(slt_pkg::K_EQUAL, '0, slt_pkg::ERR_END_OP);
                        end else begin
                            w_slot[0] = f_tok(slt_pkg::K_ERROR, '0, slt_pkg::ERR_EQ);
                            o_state.halt = 1'b1;
                        end
                    end
                    slt_pkg::M_BANG, slt_pkg::M_LT, slt_pkg::M_GT: begin
                        o_state.mode = slt_pkg::M_IDLE;
                        w_n = 2'd1;
                        if (w_c == slt_pkg::CH_EQ) begin
                            w_slot[0] = f_tok(
                                (i_state.mode == slt_pkg::M_BANG) ? slt_pkg::K_NE :
                                (i_state.mode == slt_pkg::M_LT)   ? slt_pkg::K_LE :
                                                                    slt_pkg::K_GE,
                                '0, slt_pkg::ERR_END_OP);
                        end else begin
                            w_slot[0] = f_tok(
                                (i_state.mode == slt_pkg::M_BANG) ? slt_pkg::K_NOT  :
                                (i_state.mode == slt_pkg::M_LT)   ? slt_pkg::K_LESS :
                                                                    slt_pkg::K_GREATER,
                                '0, slt_pkg::ERR_END_OP);
                            w_do_fresh = 1'b1;
                        end
                    end
                    slt_pkg::M_COLON, slt_pkg::M_SEMI: begin
                        o_state.mode = slt_pkg::M_IDLE;
                        w_n = 2'd1;
                        if (w_is_alpha) begin
                            w_slot[0] = f_tok(
                                (i_state.mode == slt_pkg::M_COLON) ? slt_pkg::K_STORE :
                                                                     slt_pkg::K_LOAD,
                                slt_pkg::t_value'(w_c), slt_pkg::ERR_END_OP);
                        end else begin
                            w_slot[0] = f_tok(slt_pkg::K_ERROR, '0, slt_pkg::ERR_VAR);
                            o_state.halt = 1'b1;
                        end
                    end
                    default: begin
                        w_do_fresh = 1'b1;
                    end
                endcase

                if (w_do_fresh) begin
                    o_state.mode = w_fresh.mode;
                    if (w_fresh.digit) begin
                        o_state.acc = slt_pkg::t_value'(w_c[3:0]);
                    end
                    if (w_fresh.emit) begin
                        w_slot[w_n[0]] = f_tok(w_fresh.kind, '0, w_fresh.err);
                        w_n = w_n + 2'd1;
                        if (w_fresh.kind == slt_pkg::K_ERROR) begin
                            o_state.halt = 1'b1;
                        end
                    end
                end
            end

            // An error clears the scan state for good.
            if (o_state.halt) begin
                o_state.mode = slt_pkg::M_IDLE;
                o_state.acc  = '0;
            end
        end

        if (w_n == 2'd1) begin
            w_slot[0].run_last = 1'b1;
        end else if (w_n == 2'd2) begin
            w_slot[1].run_last = 1'b1;
        end

        o_res.count = w_n;
        o_res.tok0  = w_slot[0];
        o_res.tok1  = w_slot[1];
    end

endmodule

@@ rtl/slt_outq.sv @@
module slt_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  slt_pkg::t_scan_res i_res,
    input  logic               i_pop,
    output logic               o_room,
    output logic               o_valid,
    output slt_pkg::t_token    o_head
);

    slt_pkg::t_token r_q [slt_pkg::QUEUE_DEPTH];
    slt_pkg::t_token n_q [slt_pkg::QUEUE_DEPTH];
    slt_pkg::t_count r_cnt;
    slt_pkg::t_count n_cnt;
    slt_pkg::t_count w_left;

    assign w_left  = r_cnt - slt_pkg::t_count'(i_pop);
    assign o_room  = (w_left <= 2'd1);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q[0];

    always_comb begin
        for (int i = 0; i < slt_pkg::QUEUE_DEPTH - 1; i++) begin
            if (i_pop) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
        end
        n_q[slt_pkg::QUEUE_DEPTH - 1] = r_q[slt_pkg::QUEUE_DEPTH - 1];
        n_cnt = w_left;
        if (i_push) begin
            for (int i = 0; i < slt_pkg::QUEUE_DEPTH; i++) begin
                if ((i_res.count != 2'd0) && (slt_pkg::t_count'(i) == w_left)) begin
                    n_q[i] = i_res.tok0;
                end
                if ((i_res.count == 2'd2) && (slt_pkg::t_count'(i) == w_left + 2'd1)) begin
                    n_q[i] = i_res.tok1;
                end
            end
            n_cnt = w_left + i_res.count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/stack_language_tokenizer_unit.sv @@
// Streaming tokenizer for a small stack language.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one source byte per
// beat, or a beat with end_marker set that closes the stream and yields an
// end-of-file token. Output channel (o_out_valid / i_out_ready / o_out_data):
// one token per beat, with run_last set on the last token that an input beat
// caused. An input beat causes zero, one or two tokens.
//
// An accepted beat waits in the input register until the queue has room, is
// scanned, and its tokens land in a three-entry result queue whose head drives
// the output. A new input beat can be taken every cycle while the queue has
// room; tokens leave through the single output port of the result queue, one
// per output beat, so a beat that yields two tokens needs two output beats.
//
// The input stage only moves on while the queue has room for two tokens, so
// when the receiver stalls, o_in_ready falls once two tokens wait in the queue
// and another beat sits in the input register; beats that yield no token are
// held as well. A synchronous reset clears the scan state, the error halt,
// the input stage and the queue. After an error token the block swallows all
// later beats, end markers included, until the next reset.
module stack_language_tokenizer_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  slt_pkg::t_char  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output slt_pkg::t_token o_out_data
);

    // Input stage.
    logic                 r_in_valid;
    slt_pkg::t_char       r_in_beat;

    // Scan state: mode, literal accumulator and the error halt.
    slt_pkg::t_scan_state r_state;
    slt_pkg::t_scan_state w_state_next;
    slt_pkg::t_scan_res   w_res;

    logic w_room;
    logic w_advance;
    logic w_pop;

    assign w_pop      = o_out_valid && i_out_ready;
    assign w_advance  = r_in_valid && w_room;
    assign o_in_ready = !r_in_valid || w_room;

    slt_scan u_scan (
        .i_beat  (r_in_beat),
        .i_state (r_state),
        .o_state (w_state_next),
        .o_res   (w_res)
    );

    slt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_advance),
        .i_res   (w_res),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .o_head  (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_beat <= i_in_data;
        end
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_state.mode <= slt_pkg::M_IDLE;
            r_state.acc  <= '0;
            r_state.halt <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_state <= w_state_next;
            end
        end
    end

endmodule

@@ rtl/slt_checker.sv @@
module slt_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input slt_pkg::t_token o_out_data
);

    logic w_out_beat;
    logic w_is_error;

    assign w_out_beat = o_out_valid && i_out_ready;
    assign w_is_error = (o_out_data.token_kind == slt_pkg::K_ERROR);

    // A stalled token holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output token changed while stalled");

    // Nothing comes out right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // An error token is the final token of the stream.
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat && w_is_error |=> !o_out_valid)
        else $error("token delivered after an error token");

    // An error token is always the last token of its input beat.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && w_is_error |-> o_out_data.run_last)
        else $error("error token without run_last");

    // Tokens other than errors carry no error code.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !w_is_error |-> (o_out_data.error_code == 3'd0))
        else $error("error code on a non-error token");

endmodule

bind stack_language_tokenizer_unit slt_checker u_slt_checker (.*);
